### src/art_pkg.sv
`default_nettype none
package art_pkg;

  localparam int unsigned MaxRegions = 16;
  localparam int unsigned PageBytes  = 4096;
  localparam logic [31:0] UserBaseReset = 32'h0020_0000;
  localparam logic [31:0] UserTopReset  = 32'h8000_0000;

  typedef enum logic [1:0] {
    FUNC_MAP    = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_CHECK  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_INV  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic {
    REG_USER_BASE = 1'b0,
    REG_USER_TOP  = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] addr;
    logic [31:0] length;
    logic [3:0]  perm_flags;
    logic        wr_access;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] region_start;
    logic [31:0] region_end;
    logic [3:0]  region_flags;
  } out_t;

  // one table entry
  typedef struct packed {
    logic [31:0] rstart;
    logic [32:0] rend;
    logic [3:0]  rflags;
  } entry_t;

  // insert control broadcast to every cell
  typedef struct packed {
    logic       ins;
    logic [8:0] pos;
    entry_t     ent;
  } ins_ctl_t;

endpackage
`default_nettype wire

### src/address_region_table.sv
`default_nettype none
// channel | valid       | stall       | payload
// in      | in_valid_i  | in_stall_o  | in_data_i  (art_pkg::in_t)
// out     | out_valid_o | out_stall_i | out_data_o (art_pkg::out_t)
// cfg     | cfg_we_i    | -           | cfg_idx_i, cfg_data_i
// lookup, clear and a rejected map: the input beat is registered, evaluated in
// S_EVAL and the result leaves from S_OUT; a map that inserts also passes through
// S_INS for the shift along the cell row; a check walks one region per cycle off
// the cell row's hit vector in S_CHK until the span is covered or a step fails
// reset empties the table and invalidates last hit; entries are not cleared
// a result waits in the output register while out_stall_i is high; no new input
// beat is taken until it has left
module address_region_table #(
  parameter int unsigned MaxRegions = art_pkg::MaxRegions,
  parameter int unsigned PageBytes  = art_pkg::PageBytes
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire art_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output art_pkg::out_t      out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [31:0]   cfg_data_i
);
  localparam int unsigned CntW = $clog2(MaxRegions + 1);
  localparam int unsigned IdxW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int unsigned PgW  = $clog2(PageBytes);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_INS  = 5'b00100,
    S_CHK  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  art_pkg::in_t req_q;
  logic [31:0] ubase_q, utop_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] lh_q;
  logic lh_v_q;
  logic [32:0] key_q, ckend_q, mend_q;
  logic [CntW-1:0] steps_q;
  logic [CntW-1:0] pos_q;
  art_pkg::out_t res_q, res_d;

  // cell row
  art_pkg::ins_ctl_t ctl;
  art_pkg::entry_t ent [MaxRegions];
  logic [MaxRegions-1:0] hit, le;

  for (genvar g = 0; g < MaxRegions; g++) begin : g_cell
    art_pkg::entry_t prev;
    if (g == 0) begin : g_first
      assign prev = ctl.ent;
    end else begin : g_rest
      assign prev = ent[g-1];
    end
    art_cell #(.Idx(g)) u_cell (
      .clk_i, .ctl_i(ctl), .prev_i(prev), .key_i(key_q),
      .ent_o(ent[g]), .hit_o(hit[g]), .le_o(le[g])
    );
  end

  // search: last hit first, else lowest valid hit
  logic            f_hit, f_lh;
  logic [IdxW-1:0] f_idx;
  logic [CntW-1:0] n_le;
  always_comb begin
    f_hit = 1'b0;
    f_idx = '0;
    f_lh  = lh_v_q && (CntW'(lh_q) < cnt_q) && hit[lh_q];
    n_le  = '0;
    for (int i = MaxRegions - 1; i >= 0; i--) begin
      if ((CntW+1)'(i) < (CntW+1)'(cnt_q) && hit[i]) begin
        f_hit = 1'b1;
        f_idx = IdxW'(i);
      end
    end
    for (int i = 0; i < MaxRegions; i++) begin
      if ((CntW+1)'(i) < (CntW+1)'(cnt_q) && le[i]) n_le = n_le + 1'b1;
    end
    if (f_lh) begin
      f_hit = 1'b1;
      f_idx = lh_q;
    end
  end

  art_pkg::entry_t fe;
  assign fe = ent[f_idx];

  // map span, rounded out; a carry past 33 bits wraps to zero and fails the window
  logic [32:0] m_sum, m_end;
  logic [31:0] m_start;
  assign m_start = {req_q.addr[31:PgW], {PgW{1'b0}}};
  assign m_sum   = {1'b0, req_q.addr} + {1'b0, req_q.length};
  assign m_end   = {m_sum[32:PgW] + (33-PgW)'(|m_sum[PgW-1:0]), {PgW{1'b0}}};

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o = res_q;

  logic cnt_full, next_ovl, m_win, c_win;
  assign cnt_full = (cnt_q >= CntW'(MaxRegions));
  assign m_win = ({1'b0, m_start} < m_end) && (m_start >= ubase_q)
                 && (m_end <= {1'b0, utop_q});
  assign c_win = (key_q < ckend_q) && (key_q[31:0] >= ubase_q)
                 && (ckend_q <= {1'b0, utop_q});
  assign next_ovl = (n_le < cnt_q) &&
                    ({1'b0, ent[n_le[IdxW-1:0]].rstart} < m_end);

  always_comb begin
    ctl.ins = (state_q == S_INS);
    ctl.pos = 9'(pos_q);
    ctl.ent.rstart = key_q[31:0];
    ctl.ent.rend   = mend_q;
    ctl.ent.rflags = req_q.perm_flags;
  end

  logic perm_ok, chk_done, chk_fail;
  assign perm_ok = (req_q.wr_access ? fe.rflags[1] : fe.rflags[0]) &&
                   !(req_q.wr_access && fe.rflags[3] &&
                     key_q < ({1'b0, fe.rstart} + 33'(PageBytes)));
  assign chk_done = (key_q >= ckend_q);
  assign chk_fail = !f_hit || (steps_q > CntW'(MaxRegions)) || !perm_ok;

  // next state and result register
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_EVAL;
      S_EVAL: begin
        res_d   = '0;
        state_d = S_OUT;
        unique case (art_pkg::func_e'(req_q.func))
          art_pkg::FUNC_MAP: begin
            if (!m_win || f_hit) res_d.status = art_pkg::ST_INV;
            else if (cnt_full) res_d.status = art_pkg::ST_FULL;
            else if (next_ovl) res_d.status = art_pkg::ST_INV;
            else begin
              res_d.region_start = m_start;
              res_d.region_end   = m_end[31:0];
              res_d.region_flags = req_q.perm_flags;
              state_d = S_INS;
            end
          end
          art_pkg::FUNC_LOOKUP: begin
            if (f_hit) begin
              res_d.found        = 1'b1;
              res_d.region_start = fe.rstart;
              res_d.region_end   = fe.rend[31:0];
              res_d.region_flags = fe.rflags;
            end
          end
          art_pkg::FUNC_CHECK: begin
            if (c_win) state_d = S_CHK;
          end
          default: ;
        endcase
      end
      S_INS:  state_d = S_OUT;
      S_CHK: begin
        // span covered once the walk point reaches the end
        if (chk_done) begin
          res_d.found = 1'b1;
          state_d = S_OUT;
        end else if (chk_fail) begin
          state_d = S_OUT;
        end
      end
      S_OUT:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ubase_q <= art_pkg::UserBaseReset;
      utop_q  <= art_pkg::UserTopReset;
      cnt_q   <= '0;
      lh_q    <= '0;
      lh_v_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          art_pkg::REG_USER_BASE: ubase_q <= cfg_data_i;
          art_pkg::REG_USER_TOP:  utop_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        req_q   <= in_data_i;
        key_q   <= (in_data_i.func == art_pkg::FUNC_MAP) ?
                   {1'b0, in_data_i.addr[31:PgW], {PgW{1'b0}}} :
                   {1'b0, in_data_i.addr};
        ckend_q <= {1'b0, in_data_i.addr} + {1'b0, in_data_i.length};
        steps_q <= '0;
      end else if (state_q == S_EVAL) begin
        unique case (art_pkg::func_e'(req_q.func))
          art_pkg::FUNC_MAP: begin
            // the search only counts when the span is in the window
            if (m_win && f_hit && !f_lh) begin
              lh_q <= f_idx; lh_v_q <= 1'b1;
            end
            pos_q  <= n_le;
            mend_q <= m_end;
          end
          art_pkg::FUNC_LOOKUP: begin
            if (f_hit && !f_lh) begin
              lh_q <= f_idx; lh_v_q <= 1'b1;
            end
          end
          art_pkg::FUNC_CHECK: ;
          default: begin
            cnt_q <= '0; lh_q <= '0; lh_v_q <= 1'b0;
          end
        endcase
      end else if (state_q == S_INS) begin
        cnt_q <= cnt_q + 1'b1;
        if (lh_v_q && CntW'(lh_q) >= pos_q) lh_q <= lh_q + 1'b1;
      end else if (state_q == S_CHK && !chk_done) begin
        // one region per cycle
        if (f_hit && !f_lh) begin
          lh_q <= f_idx; lh_v_q <= 1'b1;
        end
        if (!chk_fail) begin
          key_q   <= fe.rend;
          steps_q <= steps_q + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### src/art_cell.sv
`default_nettype none
module art_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic              clk_i,
  input  wire art_pkg::ins_ctl_t ctl_i,
  input  wire art_pkg::entry_t   prev_i,
  input  wire logic [32:0]       key_i,
  output art_pkg::entry_t        ent_o,
  output logic                   hit_o,
  output logic                   le_o
);
  art_pkg::entry_t ent_q;

  // shift from neighbor below at insert, or take the new entry
  always_ff @(posedge clk_i) begin
    if (ctl_i.ins) begin
      if (ctl_i.pos == 9'(Idx)) ent_q <= ctl_i.ent;
      else if (ctl_i.pos < 9'(Idx)) ent_q <= prev_i;
    end
  end

  assign ent_o = ent_q;
  assign hit_o = ({1'b0, ent_q.rstart} <= key_i) && (key_i < ent_q.rend);
  assign le_o  = ({1'b0, ent_q.rstart} <= key_i);
endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int unsigned TableDepth = art_pkg::MaxRegions;
  localparam longint unsigned PageSize = art_pkg::PageBytes;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  art_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  art_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_idx = 1'b0;
  logic [31:0] cfg_data = '0;

  always #1 clk = ~clk;

  address_region_table i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // shadow copy of the region table
  logic [31:0] shadow_start [TableDepth];
  logic [32:0] shadow_end [TableDepth];
  logic [3:0] shadow_flags [TableDepth];
  int unsigned shadow_count;
  int unsigned shadow_hit;
  bit shadow_hit_ok;
  logic [31:0] win_base, win_top;

  art_pkg::out_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 27;
  int recv_idle_pct = 27;
  bit recv_hold = 1'b0;

  function automatic bit span_in_window(longint unsigned s, longint unsigned e);
    return s < e && s >= longint'(win_base) && e <= longint'(win_top);
  endfunction

  // containing region, last hit tried first
  function automatic int region_at(longint unsigned a);
    if (shadow_hit_ok && shadow_hit < shadow_count &&
        longint'(shadow_start[shadow_hit]) <= a && a < longint'(shadow_end[shadow_hit]))
      return shadow_hit;
    for (int i = 0; i < shadow_count; i++) begin
      if (longint'(shadow_start[i]) <= a && a < longint'(shadow_end[i])) begin
        shadow_hit = i;
        shadow_hit_ok = 1'b1;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic art_pkg::out_t table_result(art_pkg::in_t it);
    art_pkg::out_t r;
    longint unsigned s, e, a, ln;
    int k, pos, steps;
    bit ok;
    logic [3:0] f;
    r = '0;
    a = it.addr;
    ln = it.length;
    case (art_pkg::func_e'(it.func))
      art_pkg::FUNC_MAP: begin
        s = a - (a % PageSize);
        e = ((a + ln + PageSize - 1) / PageSize) * PageSize;
        if (!span_in_window(s, e) || region_at(s) >= 0) r.status = art_pkg::ST_INV;
        else if (shadow_count >= TableDepth) r.status = art_pkg::ST_FULL;
        else begin
          pos = 0;
          while (pos < shadow_count && longint'(shadow_start[pos]) <= s) pos++;
          if (pos < shadow_count && longint'(shadow_start[pos]) < e)
            r.status = art_pkg::ST_INV;
          else begin
            for (int i = shadow_count; i > pos; i--) begin
              shadow_start[i] = shadow_start[i-1];
              shadow_end[i] = shadow_end[i-1];
              shadow_flags[i] = shadow_flags[i-1];
            end
            shadow_start[pos] = s[31:0];
            shadow_end[pos] = e[32:0];
            shadow_flags[pos] = it.perm_flags;
            shadow_count++;
            if (shadow_hit_ok && shadow_hit >= pos) shadow_hit++;
            r.status = art_pkg::ST_OK;
            r.region_start = s[31:0];
            r.region_end = e[31:0];
            r.region_flags = it.perm_flags;
          end
        end
      end
      art_pkg::FUNC_LOOKUP: begin
        k = region_at(a);
        if (k >= 0) begin
          r.found = 1'b1;
          r.region_start = shadow_start[k];
          r.region_end = shadow_end[k][31:0];
          r.region_flags = shadow_flags[k];
        end
      end
      art_pkg::FUNC_CHECK: begin
        s = a;
        e = a + ln;
        ok = span_in_window(s, e);
        steps = 0;
        while (ok && s < e) begin
          k = region_at(s);
          if (k < 0 || steps > TableDepth) ok = 1'b0;
          else begin
            f = shadow_flags[k];
            if (!(it.wr_access ? f[1] : f[0])) ok = 1'b0;
            else if (it.wr_access && f[3] && s < longint'(shadow_start[k]) + PageSize)
              ok = 1'b0;
            s = shadow_end[k];
            steps++;
          end
        end
        r.found = ok;
      end
      default: begin
        shadow_count = 0;
        shadow_hit = 0;
        shadow_hit_ok = 1'b0;
      end
    endcase
    return r;
  endfunction

  // one beat into the block; prediction made at acceptance
  task automatic send_op(art_pkg::func_e fn, logic [31:0] a, logic [31:0] ln,
                         logic [3:0] fl, logic wr);
    art_pkg::in_t it;
    it = '{func: fn, addr: a, length: ln, perm_flags: fl, wr_access: wr};
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(table_result(it));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_window(logic [31:0] base, logic [31:0] top);
    drain_results();
    cfg_we <= 1'b1;
    cfg_idx <= art_pkg::REG_USER_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_idx <= art_pkg::REG_USER_TOP;
    cfg_data <= top;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_base = base;
    win_top = top;
  endtask

  // receiver: random stall, long hold when asked
  always @(posedge clk) begin
    if (rst_n) out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // result checker, sampled at the accepting edge
  always @(posedge clk) begin
    art_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat %h", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_data.status); errors++;
        end
        if (out_data.found !== want.found) begin
          $error("found exp %0d got %0d", want.found, out_data.found); errors++;
        end
        if (out_data.region_start !== want.region_start) begin
          $error("region_start exp %h got %h", want.region_start, out_data.region_start);
          errors++;
        end
        if (out_data.region_end !== want.region_end) begin
          $error("region_end exp %h got %h", want.region_end, out_data.region_end);
          errors++;
        end
        if (out_data.region_flags !== want.region_flags) begin
          $error("region_flags exp %h got %h", want.region_flags, out_data.region_flags);
          errors++;
        end
      end
    end
  end

  // address near the window, mostly page-aligned and inside it
  function automatic logic [31:0] near_addr();
    logic [31:0] a;
    a = 32'h0020_0000 + ($urandom_range(63) << 12)
        + ($urandom_range(3) == 0 ? $urandom_range(4095) : 0);
    return a;
  endfunction

  task automatic test_directed();
    send_op(art_pkg::FUNC_LOOKUP, 32'h0020_0000, 0, 0, 0);           // empty table
    send_op(art_pkg::FUNC_MAP, 32'h0020_0010, 32'h10, 4'hF, 0);      // rounds out to a page
    send_op(art_pkg::FUNC_MAP, 32'h0020_0000, 32'h1000, 4'h3, 0);    // start already covered
    send_op(art_pkg::FUNC_MAP, 32'h0020_2000, 32'h2000, 4'h3, 0);
    send_op(art_pkg::FUNC_MAP, 32'h0020_1000, 32'h2000, 4'h1, 0);    // overlaps next region
    send_op(art_pkg::FUNC_MAP, 32'h0020_1000, 32'h1000, 4'hB, 0);    // stack, fills gap
    send_op(art_pkg::FUNC_MAP, 32'h0010_0000, 32'h1000, 4'h1, 0);    // below window
    send_op(art_pkg::FUNC_MAP, 32'h7FFF_F000, 32'h2000, 4'h1, 0);    // above window
    send_op(art_pkg::FUNC_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h1, 0); // wraps past 32 bits
    send_op(art_pkg::FUNC_MAP, 32'h0030_0000, 32'h0, 4'h1, 0);       // empty span
    send_op(art_pkg::FUNC_CHECK, 32'h0020_0000, 32'h4000, 4'h0, 0);  // read over regions
    send_op(art_pkg::FUNC_CHECK, 32'h0020_0000, 32'h4000, 4'h0, 1);  // write hits guard page
    send_op(art_pkg::FUNC_CHECK, 32'h0020_2000, 32'h2000, 4'h0, 1);
    send_op(art_pkg::FUNC_CHECK, 32'h0020_3000, 32'h2000, 4'h0, 0);  // runs past the end
    send_op(art_pkg::FUNC_CHECK, 32'h0020_0000, 32'h0, 4'h0, 0);     // zero length
    send_op(art_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0, 1);
    send_op(art_pkg::FUNC_LOOKUP, 32'h0020_1FFF, 0, 0, 0);
    send_op(art_pkg::FUNC_LOOKUP, 32'h0020_4000, 0, 0, 0);
    for (int i = 0; i < 14; i++)                                      // fill to full
      send_op(art_pkg::FUNC_MAP, 32'h0040_0000 + (i << 13), 32'h1000, 4'h7, 0);
    send_op(art_pkg::FUNC_MAP, 32'h0060_0000, 32'h1000, 4'h7, 0);    // table full
    send_op(art_pkg::FUNC_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_window();
    write_window(32'h0000_0000, 32'hFFFF_FFFF);
    send_op(art_pkg::FUNC_MAP, 32'h0, 32'h1000, 4'h3, 0);
    send_op(art_pkg::FUNC_MAP, 32'hFFFF_E000, 32'h1000, 4'h3, 0);
    send_op(art_pkg::FUNC_MAP, 32'hFFFF_F000, 32'h1, 4'h3, 0);       // end beyond top
    send_op(art_pkg::FUNC_CHECK, 32'h0, 32'h1000, 0, 0);
    send_op(art_pkg::FUNC_CLEAR, 0, 0, 0, 0);
    write_window(32'h0040_0000, 32'h0040_8000);
    send_op(art_pkg::FUNC_MAP, 32'h0040_0000, 32'h8000, 4'h3, 0);
    send_op(art_pkg::FUNC_CHECK, 32'h0040_7000, 32'h1000, 0, 1);
    send_op(art_pkg::FUNC_CLEAR, 0, 0, 0, 0);
    write_window(art_pkg::UserBaseReset, art_pkg::UserTopReset);
  endtask

  task automatic random_op();
    int pick;
    logic [31:0] a, ln;
    pick = $urandom_range(99);
    a = ($urandom_range(9) == 0) ? $urandom() : near_addr();
    ln = ($urandom_range(9) == 0) ? $urandom() :
         ($urandom_range(4) << 12) + $urandom_range(4095);
    if (pick < 35)
      send_op(art_pkg::FUNC_MAP, a, ln, 4'($urandom()), 1'($urandom()));
    else if (pick < 60)
      send_op(art_pkg::FUNC_LOOKUP, a, $urandom(), 4'($urandom()), 1'($urandom()));
    else if (pick < 97)
      send_op(art_pkg::FUNC_CHECK, a, ln, 4'($urandom()), 1'($urandom()));
    else
      send_op(art_pkg::FUNC_CLEAR, $urandom(), $urandom(), 4'($urandom()), 1'($urandom()));
  endtask

  task automatic test_random();
    for (int i = 0; i < 300; i++) random_op();
    send_idle_pct = 0;                                          // stretch with no idling
    recv_idle_pct = 0;
    for (int i = 0; i < 150; i++) random_op();
    send_idle_pct = 27;
    recv_idle_pct = 27;
    write_window(32'h0020_0000, 32'h0030_0000);
    for (int i = 0; i < 200; i++) random_op();
    write_window(art_pkg::UserBaseReset, art_pkg::UserTopReset);
    for (int i = 0; i < 150; i++) random_op();
  endtask

  task automatic test_backpressure();
    drain_results();                                            // sender waits for all results
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 20; i++) random_op();
    join
  endtask

  initial begin
    shadow_count = 0;
    shadow_hit = 0;
    shadow_hit_ok = 1'b0;
    win_base = art_pkg::UserBaseReset;
    win_top = art_pkg::UserTopReset;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_window();
    test_backpressure();
    test_random();
    drain_results();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
